>>> rtl/sact_pkg.sv
// Shared constants, types and state codes for the set-associative coordinate table.
`timescale 1ns / 1ps
package sact_pkg;

   // NUM_SETS must be a power of two: the set index is the low bits of the key mix.
   localparam int NUM_SETS  = 256;
   localparam int NUM_WAYS  = 4;
   localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int KEY_W     = 64;
   localparam int HANDLE_W  = 32;
   localparam int STAMP_W   = 64;
   localparam int MIX_SHL   = 6;
   localparam int MIX_SHR   = 2;
   localparam logic [63:0] MIX_CONST = 64'h0000_0000_9e37_79b9;

   localparam int NUM_WAYS_M1 = NUM_WAYS - 1;

   // Request operation codes.
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_STORE  = 1'b1;

   typedef logic [NUM_WAYS-1:0] way_vec_type;
   typedef logic [SET_W-1:0]    set_idx_type;
   typedef logic [WAY_W-1:0]    way_idx_type;

   // One memory row holds a whole set, so a single read returns every way.
   typedef struct packed {
      logic [NUM_WAYS-1:0]               valid;
      logic [NUM_WAYS-1:0][KEY_W-1:0]    key_x;
      logic [NUM_WAYS-1:0][KEY_W-1:0]    key_y;
      logic [NUM_WAYS-1:0][HANDLE_W-1:0] handle;
      logic [NUM_WAYS-1:0][STAMP_W-1:0]  stamp;
   } row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_DECIDE
   } state_type;

   // Low SET_W bits of kx ^ (ky + MIX_CONST + (kx << 6) + (kx >> 2)).
   // Carries only travel upwards, so the narrow sum gives the same low bits.
   function automatic set_idx_type mix_set(input logic [KEY_W-1:0] kx,
                                           input logic [KEY_W-1:0] ky);
      logic [KEY_W-1:0] shl;
      logic [KEY_W-1:0] shr;
      set_idx_type      sum;
      shl = kx << MIX_SHL;
      shr = kx >> MIX_SHR;
      sum = ky[SET_W-1:0] + MIX_CONST[SET_W-1:0] + shl[SET_W-1:0] + shr[SET_W-1:0];
      return kx[SET_W-1:0] ^ sum;
   endfunction

endpackage

>>> rtl/sact_req_if.sv
// Request channel interface: valid/ready handshake with the lookup or store payload.
`timescale 1ns / 1ps
interface sact_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [63:0] key_x;
   logic signed [63:0] key_y;
   logic [31:0]        handle;

   modport source (output valid, output op, output key_x, output key_y, output handle,
                   input ready);
   modport sink   (input valid, input op, input key_x, input key_y, input handle,
                   output ready);
endinterface

>>> rtl/sact_rsp_if.sv
// Response channel interface: valid/ready handshake with the hit and eviction payload.
`timescale 1ns / 1ps
interface sact_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] found_handle;
   logic        evicted;
   logic [31:0] evicted_handle;

   modport source (output valid, output hit, output found_handle, output evicted,
                   output evicted_handle, input ready);
   modport sink   (input valid, input hit, input found_handle, input evicted,
                   input evicted_handle, output ready);
endinterface

>>> rtl/set_assoc_coord_table_fifo_evict.sv
// Set-associative coordinate table with FIFO replacement, built around one set-wide memory.
// An accepted request beat has its set row read into rd_row_ff, its compares registered in
// the evaluate step and its response beat registered in the decide step. The block takes
// one request at a time, set by the memory read-evaluate-write turn on the single set row;
// a full response register holds the decide step until the beat is taken. Reset: synchronous,
// active high; afterwards a clearing pass writes every set row, accepting no request beat.
`timescale 1ns / 1ps
module set_assoc_coord_table_fifo_evict (
   input logic       clock,
   input logic       reset,
   sact_req_if.sink   req_chan,
   sact_rsp_if.source rsp_chan
);
   import sact_pkg::*;

   // The whole table lives in one memory, one row per set. Every request reads
   // its row once, and a store writes the updated row back in the decide step.
   // The block handles one request at a time, so a read never overtakes the
   // write-back of the previous request and no forwarding is needed.
   row_type mem [NUM_SETS];

   state_type state_ff, state_in;

   set_idx_type clr_idx_ff, clr_idx_in;
   set_idx_type set_ff;
   logic        op_ff;
   logic [KEY_W-1:0]    key_x_ff, key_y_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [STAMP_W-1:0]  insert_count_ff, insert_count_in;

   row_type rd_row_ff;

   // Evaluation results registered between the compare and the decide step.
   way_vec_type match_ff, match_in;
   way_vec_type free_ff,  free_in;
   logic [NUM_WAYS-1:0][NUM_WAYS-1:0] lt_ff, lt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [HANDLE_W-1:0] rsp_found_ff;
   logic                rsp_evicted_ff;
   logic [HANDLE_W-1:0] rsp_evicted_handle_ff;

   logic        accept;
   logic        slot_free;
   logic        is_store;
   logic        mem_re;
   logic        mem_we;
   set_idx_type mem_waddr;
   row_type     mem_wdata;
   set_idx_type req_set;

   // Decide-step signals.
   way_vec_type oldest;
   way_idx_type hit_way, free_way, old_way, slot_way;
   logic        any_hit, any_free;
   row_type     upd_row;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign is_store  = (op_ff == OP_STORE);
   assign req_set   = mix_set(req_chan.key_x, req_chan.key_y);

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_row_ff <= mem[req_set];
      end
   end

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == set_idx_type'(NUM_SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_chan.ready = 1'b0;
      mem_re         = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = set_ff;
      mem_wdata      = upd_row;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            mem_re         = req_chan.valid;
         end
         ST_EVAL: begin
         end
         ST_DECIDE: begin
            mem_we = slot_free && is_store;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------- evaluate
   // All the way-against-way stamp compares run side by side, so the oldest
   // way is found with one compare in depth rather than a chain of them.
   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         free_in[w]  = !rd_row_ff.valid[w];
         match_in[w] = rd_row_ff.valid[w] &&
                       (rd_row_ff.key_x[w] == key_x_ff) &&
                       (rd_row_ff.key_y[w] == key_y_ff);
         for (int v = 0; v < NUM_WAYS; v++) begin
            lt_in[w][v] = rd_row_ff.stamp[w] < rd_row_ff.stamp[v];
         end
      end
   end

   // --------------------------------------------------------------- decide
   // A way is the oldest when it is strictly older than every lower way and
   // no higher way is strictly older, which gives the lowest way on ties.
   always_comb begin
      for (int w = 0; w < NUM_WAYS; w++) begin
         oldest[w] = 1'b1;
         for (int v = 0; v < NUM_WAYS; v++) begin
            if (v < w) begin
               oldest[w] = oldest[w] && lt_ff[w][v];
            end else if (v > w) begin
               oldest[w] = oldest[w] && !lt_ff[v][w];
            end
         end
      end
   end

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      old_way  = '0;
      for (int w = NUM_WAYS_M1; w >= 0; w--) begin
         if (match_ff[w]) hit_way  = way_idx_type'(w);
         if (free_ff[w])  free_way = way_idx_type'(w);
         if (oldest[w])   old_way  = way_idx_type'(w);
      end
      any_hit  = |match_ff;
      any_free = |free_ff;
      slot_way = any_free ? free_way : old_way;

      upd_row                  = rd_row_ff;
      upd_row.valid[slot_way]  = 1'b1;
      upd_row.key_x[slot_way]  = key_x_ff;
      upd_row.key_y[slot_way]  = key_y_ff;
      upd_row.handle[slot_way] = handle_ff;
      upd_row.stamp[slot_way]  = insert_count_ff;
   end

   // --------------------------------------------------------- control next
   always_comb begin
      clr_idx_in      = clr_idx_ff;
      insert_count_in = insert_count_ff;
      rsp_valid_in    = rsp_valid_ff;
      if (state_ff == ST_CLEAR) begin
         clr_idx_in = clr_idx_ff + set_idx_type'(1);
      end
      if (state_ff == ST_DECIDE && slot_free && is_store) begin
         insert_count_in = insert_count_ff + STAMP_W'(1);
      end
      if (state_ff == ST_DECIDE && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_idx_ff      <= '0;
         insert_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_idx_ff      <= clr_idx_in;
         insert_count_ff <= insert_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // --------------------------------------------------------- payload regs
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff    <= req_set;
         op_ff     <= req_chan.op;
         key_x_ff  <= req_chan.key_x;
         key_y_ff  <= req_chan.key_y;
         handle_ff <= req_chan.handle;
      end
      if (state_ff == ST_EVAL) begin
         match_ff <= match_in;
         free_ff  <= free_in;
         lt_ff    <= lt_in;
      end
      if (state_ff == ST_DECIDE && slot_free) begin
         // A lookup reports only hit fields; a store reports only eviction fields.
         rsp_hit_ff            <= !is_store && any_hit;
         rsp_found_ff          <= (!is_store && any_hit) ? rd_row_ff.handle[hit_way] : '0;
         rsp_evicted_ff        <= is_store && !any_free;
         rsp_evicted_handle_ff <= (is_store && !any_free) ? rd_row_ff.handle[old_way] : '0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.hit            = rsp_hit_ff;
   assign rsp_chan.found_handle   = rsp_found_ff;
   assign rsp_chan.evicted        = rsp_evicted_ff;
   assign rsp_chan.evicted_handle = rsp_evicted_handle_ff;

endmodule
